// File: hw/rtl/swpl_pkg.sv
// Shared types and codes of the sorted weight priority list.
package swpl_pkg;

    // Command codes on i_command.
    localparam logic [1:0] CMD_COUNT  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_TAG,
        S_FIND_POS,
        S_RUN,
        S_FIX_I,
        S_FIX_J,
        S_SHIFT,
        S_PLACE,
        S_PULL
    } t_state;

    // What the list walk tests or moves.
    typedef enum logic [2:0] {
        WM_NONE,
        WM_TAG,
        WM_GE,
        WM_LT,
        WM_UP,
        WM_PULL
    } t_walk_mode;

    typedef enum logic [1:0] {
        SS_ZERO,
        SS_AFTER,
        SS_TOP
    } t_start_sel;

    typedef enum logic [1:0] {
        PS_ZERO,
        PS_HIT,
        PS_FILL
    } t_pos_sel;

    typedef enum logic [2:0] {
        WS_NONE,
        WS_WALK,
        WS_PLACE,
        WS_FIX_I,
        WS_FIX_J
    } t_wr_sel;

    typedef struct packed {
        logic       accept;
        logic       walk_start;
        t_start_sel start_sel;
        logic       walk_en;
        t_walk_mode mode;
        logic       cap_hit;
        logic       set_pos;
        t_pos_sel   pos_sel;
        t_wr_sel    wr_sel;
        logic       fill_inc;
        logic       fill_dec;
        logic       emit;
        logic       emit_out;
        t_status    status;
    } t_dp_cmd;

    typedef struct packed {
        logic found;
        logic walk_idle;
        logic sat;
        logic full;
        logic empty;
        logic swap;
    } t_dp_stat;

endpackage

// File: hw/rtl/swpl_ctrl.sv
// Controller state machine of the sorted weight priority list.
module swpl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_command,
    input  swpl_pkg::t_dp_stat i_stat,
    output logic               busy,
    output swpl_pkg::t_dp_cmd  o_cmd
);

    swpl_pkg::t_state r_state;
    swpl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swpl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            swpl_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    case (i_command)
                        swpl_pkg::CMD_COUNT: begin
                            o_cmd.walk_start = 1'b1;
                            o_cmd.start_sel  = swpl_pkg::SS_ZERO;
                            n_state          = swpl_pkg::S_FIND_TAG;
                        end
                        swpl_pkg::CMD_INSERT: begin
                            if (i_stat.full) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = swpl_pkg::ST_FULL;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                o_cmd.start_sel  = swpl_pkg::SS_ZERO;
                                n_state          = swpl_pkg::S_FIND_POS;
                            end
                        end
                        swpl_pkg::CMD_REMOVE: begin
                            if (i_stat.empty) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = swpl_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                o_cmd.start_sel  = swpl_pkg::SS_ZERO;
                                n_state          = swpl_pkg::S_PULL;
                            end
                        end
                        default: begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = swpl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            swpl_pkg::S_FIND_TAG: begin
                o_cmd.walk_en = 1'b1;
                o_cmd.mode    = swpl_pkg::WM_TAG;
                if (i_stat.found) begin
                    if (i_stat.sat) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = swpl_pkg::ST_SAT;
                        n_state      = swpl_pkg::S_IDLE;
                    end else begin
                        o_cmd.cap_hit    = 1'b1;
                        o_cmd.walk_start = 1'b1;
                        o_cmd.start_sel  = swpl_pkg::SS_AFTER;
                        n_state          = swpl_pkg::S_RUN;
                    end
                end else if (i_stat.walk_idle) begin
                    if (i_stat.full) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = swpl_pkg::ST_FULL;
                        n_state      = swpl_pkg::S_IDLE;
                    end else begin
                        // A new symbol goes in at the front of the list.
                        o_cmd.set_pos = 1'b1;
                        o_cmd.pos_sel = swpl_pkg::PS_ZERO;
                        if (i_stat.empty) begin
                            n_state = swpl_pkg::S_PLACE;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            o_cmd.start_sel  = swpl_pkg::SS_TOP;
                            n_state          = swpl_pkg::S_SHIFT;
                        end
                    end
                end
            end
            swpl_pkg::S_FIND_POS: begin
                o_cmd.walk_en = 1'b1;
                o_cmd.mode    = swpl_pkg::WM_GE;
                if (i_stat.found) begin
                    o_cmd.set_pos    = 1'b1;
                    o_cmd.pos_sel    = swpl_pkg::PS_HIT;
                    o_cmd.walk_start = 1'b1;
                    o_cmd.start_sel  = swpl_pkg::SS_TOP;
                    n_state          = swpl_pkg::S_SHIFT;
                end else if (i_stat.walk_idle) begin
                    o_cmd.set_pos = 1'b1;
                    o_cmd.pos_sel = swpl_pkg::PS_FILL;
                    n_state       = swpl_pkg::S_PLACE;
                end
            end
            swpl_pkg::S_RUN: begin
                o_cmd.walk_en = 1'b1;
                o_cmd.mode    = swpl_pkg::WM_LT;
                if (i_stat.found || i_stat.walk_idle) begin
                    n_state = swpl_pkg::S_FIX_I;
                end
            end
            swpl_pkg::S_FIX_I: begin
                o_cmd.wr_sel = swpl_pkg::WS_FIX_I;
                if (i_stat.swap) begin
                    n_state = swpl_pkg::S_FIX_J;
                end else begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = swpl_pkg::ST_OK;
                    n_state      = swpl_pkg::S_IDLE;
                end
            end
            swpl_pkg::S_FIX_J: begin
                o_cmd.wr_sel = swpl_pkg::WS_FIX_J;
                o_cmd.emit   = 1'b1;
                o_cmd.status = swpl_pkg::ST_OK;
                n_state      = swpl_pkg::S_IDLE;
            end
            swpl_pkg::S_SHIFT: begin
                o_cmd.walk_en = 1'b1;
                o_cmd.mode    = swpl_pkg::WM_UP;
                o_cmd.wr_sel  = swpl_pkg::WS_WALK;
                if (i_stat.walk_idle) begin
                    n_state = swpl_pkg::S_PLACE;
                end
            end
            swpl_pkg::S_PLACE: begin
                o_cmd.wr_sel   = swpl_pkg::WS_PLACE;
                o_cmd.fill_inc = 1'b1;
                o_cmd.emit     = 1'b1;
                o_cmd.status   = swpl_pkg::ST_OK;
                n_state        = swpl_pkg::S_IDLE;
            end
            swpl_pkg::S_PULL: begin
                o_cmd.walk_en = 1'b1;
                o_cmd.mode    = swpl_pkg::WM_PULL;
                o_cmd.wr_sel  = swpl_pkg::WS_WALK;
                if (i_stat.walk_idle) begin
                    o_cmd.fill_dec = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_out = 1'b1;
                    o_cmd.status   = swpl_pkg::ST_OK;
                    n_state        = swpl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swpl_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != swpl_pkg::S_IDLE);

endmodule

// File: hw/rtl/swpl_dpath.sv
// Datapath of the sorted weight priority list: entry memory, list walk and result registers.
module swpl_dpath #(
    parameter int  MAX_ENTRIES = 512,
    parameter int  WEIGHT_BITS = 20,
    parameter int  TAG_BITS    = 9,
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_command,
    input  logic [TAG_BITS-1:0]    i_in_tag,
    input  logic [WEIGHT_BITS-1:0] i_in_weight,
    input  swpl_pkg::t_dp_cmd      i_cmd,
    output swpl_pkg::t_dp_stat     o_stat,
    output logic                   o_strobe,
    output logic [1:0]             o_status,
    output logic [TAG_BITS-1:0]    o_out_tag,
    output logic [WEIGHT_BITS-1:0] o_out_weight,
    output logic [CNT_W-1:0]       o_entries_held
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int WORD_W = WEIGHT_BITS + TAG_BITS;

    logic [WORD_W-1:0] mem [MAX_ENTRIES];

    // Latched transaction fields.
    logic [TAG_BITS-1:0]    r_in_t;
    logic [WEIGHT_BITS-1:0] r_in_w;
    logic [WEIGHT_BITS-1:0] r_new_w;

    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;

    // List walk: one read issued per cycle, its data registered and back in the next cycle.
    logic [CNT_W-1:0]  r_rp;
    logic              r_down;
    logic              r_issue;
    logic              r_rd_vld;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [WORD_W-1:0] r_rdata;

    // Entry hit by a count, and the last entry of the run behind it.
    logic [CNT_W-1:0]       r_i;
    logic [TAG_BITS-1:0]    r_ti;
    logic [WEIGHT_BITS-1:0] r_wnew;
    logic [CNT_W-1:0]       r_j;
    logic [TAG_BITS-1:0]    r_tj;
    logic [WEIGHT_BITS-1:0] r_wj;
    logic                   r_any;
    logic [CNT_W-1:0]       r_pos;

    logic [TAG_BITS-1:0]    r_out_t;
    logic [WEIGHT_BITS-1:0] r_out_w;

    logic                   r_strobe;
    swpl_pkg::t_status      r_status;
    logic [TAG_BITS-1:0]    r_o_tag;
    logic [WEIGHT_BITS-1:0] r_o_weight;
    logic [CNT_W-1:0]       r_held;

    logic [WEIGHT_BITS-1:0] rd_w;
    logic [TAG_BITS-1:0]    rd_t;
    logic                   cond;
    logic                   found;
    logic                   walk_idle;
    logic                   step;
    logic [CNT_W-1:0]       start_ptr;
    logic                   start_down;
    logic [CNT_W-1:0]       rp_inc;
    logic                   we;
    logic [CNT_W-1:0]       wptr;
    logic [WORD_W-1:0]      wdata;

    assign rd_w   = r_rdata[WORD_W-1:TAG_BITS];
    assign rd_t   = r_rdata[TAG_BITS-1:0];
    assign step   = i_cmd.walk_en && !i_cmd.walk_start;
    assign rp_inc = r_rp + CNT_W'(1);

    always_comb begin
        case (i_cmd.mode)
            swpl_pkg::WM_TAG: cond = (rd_t == r_in_t);
            swpl_pkg::WM_GE:  cond = (rd_w >= r_in_w);
            swpl_pkg::WM_LT:  cond = (rd_w >= r_wnew);
            default:          cond = 1'b0;
        endcase
    end

    assign found     = i_cmd.walk_en && r_rd_vld && cond;
    assign walk_idle = !r_issue && !r_rd_vld;

    always_comb begin
        start_down = 1'b0;
        case (i_cmd.start_sel)
            swpl_pkg::SS_ZERO:  start_ptr = '0;
            swpl_pkg::SS_AFTER: start_ptr = r_rd_idx + CNT_W'(1);
            swpl_pkg::SS_TOP: begin
                start_ptr  = r_fill - CNT_W'(1);
                start_down = 1'b1;
            end
            default:            start_ptr = '0;
        endcase
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.fill_inc) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (i_cmd.fill_dec) begin
            n_fill = r_fill - CNT_W'(1);
        end
    end

    // Write port: shifting writes each entry read back one place above (insert) or below (remove) it.
    always_comb begin
        we    = 1'b0;
        wptr  = '0;
        wdata = r_rdata;
        case (i_cmd.wr_sel)
            swpl_pkg::WS_WALK: begin
                if (r_rd_vld && i_cmd.mode == swpl_pkg::WM_UP) begin
                    we   = 1'b1;
                    wptr = r_rd_idx + CNT_W'(1);
                end else if (r_rd_vld && i_cmd.mode == swpl_pkg::WM_PULL
                             && r_rd_idx != '0) begin
                    we   = 1'b1;
                    wptr = r_rd_idx - CNT_W'(1);
                end
            end
            swpl_pkg::WS_PLACE: begin
                we    = 1'b1;
                wptr  = r_pos;
                wdata = {r_new_w, r_in_t};
            end
            swpl_pkg::WS_FIX_I: begin
                we    = 1'b1;
                wptr  = r_i;
                wdata = r_any ? {r_wj, r_tj} : {r_wnew, r_ti};
            end
            swpl_pkg::WS_FIX_J: begin
                we    = 1'b1;
                wptr  = r_j;
                wdata = {r_wnew, r_ti};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wptr[IDX_W-1:0]] <= wdata;
        end
        if (step && r_issue) begin
            r_rdata <= mem[r_rp[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_any    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_strobe <= i_cmd.emit;
            if (i_cmd.walk_start) begin
                r_issue  <= start_down ? 1'b1 : (start_ptr < r_fill);
                r_rd_vld <= 1'b0;
                r_any    <= 1'b0;
            end else if (i_cmd.walk_en) begin
                r_rd_vld <= r_issue;
                if (r_issue) begin
                    r_issue <= r_down ? (r_rp != r_pos) : (rp_inc < r_fill);
                end
                if (i_cmd.mode == swpl_pkg::WM_LT && r_rd_vld && !cond) begin
                    r_any <= 1'b1;
                end
            end else begin
                r_issue  <= 1'b0;
                r_rd_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_t  <= i_in_tag;
            r_in_w  <= i_in_weight;
            r_new_w <= (i_command == swpl_pkg::CMD_COUNT) ? WEIGHT_BITS'(1) : i_in_weight;
        end
        if (i_cmd.walk_start) begin
            r_rp   <= start_ptr;
            r_down <= start_down;
        end else if (step && r_issue) begin
            r_rd_idx <= r_rp;
            r_rp     <= r_down ? (r_rp - CNT_W'(1)) : rp_inc;
        end
        if (i_cmd.cap_hit) begin
            r_i    <= r_rd_idx;
            r_ti   <= rd_t;
            r_wnew <= rd_w + WEIGHT_BITS'(1);
        end
        // Entries that still weigh less than the bumped count form the run to pass.
        if (step && i_cmd.mode == swpl_pkg::WM_LT && r_rd_vld && !cond) begin
            r_j  <= r_rd_idx;
            r_tj <= rd_t;
            r_wj <= rd_w;
        end
        if (step && i_cmd.mode == swpl_pkg::WM_PULL && r_rd_vld && r_rd_idx == '0) begin
            r_out_t <= rd_t;
            r_out_w <= rd_w;
        end
        if (i_cmd.set_pos) begin
            case (i_cmd.pos_sel)
                swpl_pkg::PS_ZERO: r_pos <= '0;
                swpl_pkg::PS_HIT:  r_pos <= r_rd_idx;
                swpl_pkg::PS_FILL: r_pos <= r_fill;
                default:           r_pos <= '0;
            endcase
        end
        if (i_cmd.emit) begin
            r_status   <= i_cmd.status;
            r_o_tag    <= i_cmd.emit_out ? r_out_t : '0;
            r_o_weight <= i_cmd.emit_out ? r_out_w : '0;
            r_held     <= n_fill;
        end
    end

    assign o_stat.found     = found;
    assign o_stat.walk_idle = walk_idle;
    assign o_stat.sat       = (rd_w == {WEIGHT_BITS{1'b1}});
    assign o_stat.full      = (r_fill == CNT_W'(MAX_ENTRIES));
    assign o_stat.empty     = (r_fill == '0);
    assign o_stat.swap      = r_any;

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_tag      = r_o_tag;
    assign o_out_weight   = r_o_weight;
    assign o_entries_held = r_held;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond list depth");

    a_fill_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_fill) |-> r_strobe)
        else $error("fill count changed without a result");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status != swpl_pkg::ST_OK) |-> (r_o_tag == '0 && r_o_weight == '0))
        else $error("failed transaction carries entry data");

    a_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (wptr <= r_fill && wptr < CNT_W'(MAX_ENTRIES)))
        else $error("memory write outside the held list");

endmodule

// File: hw/rtl/sorted_weight_priority_list.sv
// Sorted weight priority list: a (weight, tag) list in ascending weight order for Huffman coding.
//
// A transaction is taken when start is high and busy is low; its single result appears on the
// o_ ports for exactly one cycle with o_strobe high and must be captured then, as the receiver
// cannot stall the block. Entries sit in one single-port-write, single-port-read memory that
// the block walks one entry per cycle, so the latency follows the list length F and the place
// that is touched. A count of a held symbol walks to its place and along the lighter run behind
// it, a count of a new symbol walks the whole list and then shifts it up, an insert walks to its
// place and shifts the entries above it, a remove walks the whole list, and a full insert, an
// empty remove or an unused command needs no walk. Memory contents need no clearing after reset.
module sorted_weight_priority_list #(
    parameter int  MAX_ENTRIES = 512,
    parameter int  WEIGHT_BITS = 20,
    parameter int  TAG_BITS    = 9,
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_command,
    input  logic [TAG_BITS-1:0]    i_in_tag,
    input  logic [WEIGHT_BITS-1:0] i_in_weight,
    output logic                   o_strobe,
    output logic [1:0]             o_status,
    output logic [TAG_BITS-1:0]    o_out_tag,
    output logic [WEIGHT_BITS-1:0] o_out_weight,
    output logic [CNT_W-1:0]       o_entries_held
);

    swpl_pkg::t_dp_cmd  dp_cmd;
    swpl_pkg::t_dp_stat dp_stat;

    swpl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .busy      (busy),
        .o_cmd     (dp_cmd)
    );

    swpl_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_command),
        .i_in_tag       (i_in_tag),
        .i_in_weight    (i_in_weight),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_out_tag      (o_out_tag),
        .o_out_weight   (o_out_weight),
        .o_entries_held (o_entries_held)
    );

endmodule

// File: tb/sorted_weight_priority_list_test.sv
// Self-checking testbench for the sorted weight priority list: directed and random commands.
module sorted_weight_priority_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH    = 512;
    localparam int WGT_W         = 20;
    localparam int TAG_W         = 9;
    localparam int HELD_W        = $clog2(LIST_DEPTH + 1);
    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 64;
    localparam int QUIET_LIMIT   = 12000;
    localparam int MIX_ITEMS     = 60;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        swpl_pkg::t_status   status;
        logic [TAG_W-1:0]    tag;
        logic [WGT_W-1:0]    weight;
        logic [HELD_W-1:0]   held;
    } t_list_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic [1:0]         i_command   = swpl_pkg::CMD_COUNT;
    logic [TAG_W-1:0]   i_in_tag    = '0;
    logic [WGT_W-1:0]   i_in_weight = '0;
    logic               busy;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [TAG_W-1:0]   o_out_tag;
    logic [WGT_W-1:0]   o_out_weight;
    logic [HELD_W-1:0]  o_entries_held;

    // Predicted list contents, kept in step with every accepted transaction.
    logic [WGT_W-1:0]   list_weight [LIST_DEPTH];
    logic [TAG_W-1:0]   list_tag    [LIST_DEPTH];
    int                 list_fill = 0;

    t_list_result       pending_results [$];
    int                 errors             = 0;
    int                 items_sent         = 0;
    int                 results_checked    = 0;
    int                 peak_fill          = 0;
    int                 moves_past_lighter = 0;
    int                 burst_left         = 0;
    int                 quiet_cycles       = 0;
    int                 status_seen [4]    = '{0, 0, 0, 0};

    sorted_weight_priority_list #(
        .MAX_ENTRIES (LIST_DEPTH),
        .WEIGHT_BITS (WGT_W),
        .TAG_BITS    (TAG_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_in_tag       (i_in_tag),
        .i_in_weight    (i_in_weight),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_out_tag      (o_out_tag),
        .o_out_weight   (o_out_weight),
        .o_entries_held (o_entries_held)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [TAG_W-1:0] rand_tag();
        return TAG_W'($urandom());
    endfunction

    function automatic logic [WGT_W-1:0] rand_weight();
        return WGT_W'($urandom());
    endfunction

    function automatic void open_slot(input int pos);
        int k;
        for (k = list_fill; k > pos; k--) begin
            list_weight[k] = list_weight[k - 1];
            list_tag[k]    = list_tag[k - 1];
        end
    endfunction

    function automatic t_list_result apply_command(input logic [1:0] cmd,
                                                   input logic [TAG_W-1:0] tag,
                                                   input logic [WGT_W-1:0] weight);
        t_list_result     res;
        int               hit;
        int               j;
        int               k;
        logic [WGT_W-1:0] bumped;
        logic [TAG_W-1:0] moved_tag;
        res        = '0;
        res.status = swpl_pkg::ST_OK;
        case (cmd)
            swpl_pkg::CMD_COUNT: begin
                hit = -1;
                for (k = 0; k < list_fill && hit < 0; k++)
                    if (list_tag[k] == tag) hit = k;
                if (hit >= 0) begin
                    if (list_weight[hit] == '1) begin
                        res.status = swpl_pkg::ST_SAT;
                    end else begin
                        bumped           = list_weight[hit] + 1'b1;
                        list_weight[hit] = bumped;
                        // The bumped entry trades places with the last lighter entry of the
                        // run that follows it.
                        if (hit + 1 < list_fill && list_weight[hit + 1] < bumped) begin
                            j = hit + 1;
                            while (j + 1 < list_fill && list_weight[j + 1] < bumped) j++;
                            moved_tag        = list_tag[hit];
                            list_tag[hit]    = list_tag[j];
                            list_tag[j]      = moved_tag;
                            list_weight[hit] = list_weight[j];
                            list_weight[j]   = bumped;
                            moves_past_lighter++;
                        end
                    end
                end else if (list_fill >= LIST_DEPTH) begin
                    res.status = swpl_pkg::ST_FULL;
                end else begin
                    open_slot(0);
                    list_tag[0]    = tag;
                    list_weight[0] = WGT_W'(1);
                    list_fill++;
                end
            end
            swpl_pkg::CMD_INSERT: begin
                if (list_fill >= LIST_DEPTH) begin
                    res.status = swpl_pkg::ST_FULL;
                end else begin
                    hit = list_fill;
                    for (k = list_fill - 1; k >= 0; k--)
                        if (list_weight[k] >= weight) hit = k;
                    open_slot(hit);
                    list_tag[hit]    = tag;
                    list_weight[hit] = weight;
                    list_fill++;
                end
            end
            swpl_pkg::CMD_REMOVE: begin
                if (list_fill == 0) begin
                    res.status = swpl_pkg::ST_EMPTY;
                end else begin
                    res.tag    = list_tag[0];
                    res.weight = list_weight[0];
                    for (k = 1; k < list_fill; k++) begin
                        list_weight[k - 1] = list_weight[k];
                        list_tag[k - 1]    = list_tag[k];
                    end
                    list_fill--;
                end
            end
            default: ;
        endcase
        if (list_fill > peak_fill) peak_fill = list_fill;
        res.held = HELD_W'(list_fill);
        return res;
    endfunction

    function automatic logic [WGT_W-1:0] pick_weight();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return '1;
            2: return {WGT_W{1'b1}} - 1'b1;
            3, 4: return WGT_W'($urandom_range(1, 6));
            5: begin
                if (list_fill > 0) return list_weight[$urandom_range(0, list_fill - 1)];
                return WGT_W'($urandom_range(0, 3));
            end
            default: return rand_weight();
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] pick_present_tag();
        if (list_fill == 0) return rand_tag();
        return list_tag[$urandom_range(0, list_fill - 1)];
    endfunction

    function automatic logic [TAG_W-1:0] pick_count_tag();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return TAG_W'($urandom_range(0, 15));
        if (sel < 8) return pick_present_tag();
        return rand_tag();
    endfunction

    function automatic int find_absent_tag();
        int t;
        int k;
        logic seen;
        for (t = 0; t < (1 << TAG_W); t++) begin
            seen = 1'b0;
            for (k = 0; k < list_fill; k++)
                if (list_tag[k] == t) seen = 1'b1;
            if (!seen) return t;
        end
        return -1;
    endfunction

    // Sends one transaction; the sender runs in bursts with random gaps in between.
    task automatic send_item(input logic [1:0] cmd, input logic [TAG_W-1:0] tag,
                             input logic [WGT_W-1:0] weight);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(30, 120);
            else burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 20);
            if (gap > 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        start       <= 1'b1;
        i_command   <= cmd;
        i_in_tag    <= tag;
        i_in_weight <= weight;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_command(cmd, tag, weight));
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_and_unused();
        send_item(swpl_pkg::CMD_REMOVE, '0, '0);
        send_item(CMD_UNUSED, '1, '1);
    endtask

    task automatic test_count_ordering();
        send_item(swpl_pkg::CMD_COUNT, 9'd0, '0);
        send_item(swpl_pkg::CMD_COUNT, 9'd511, '1);
        send_item(swpl_pkg::CMD_COUNT, 9'd511, '0);
        send_item(swpl_pkg::CMD_INSERT, 9'h100, 20'd2);
        send_item(swpl_pkg::CMD_COUNT, 9'd0, '0);
        send_item(swpl_pkg::CMD_COUNT, 9'd0, '0);
    endtask

    task automatic test_insert_ordering();
        send_item(swpl_pkg::CMD_INSERT, 9'h155, '0);
        send_item(swpl_pkg::CMD_INSERT, 9'h0AA, '1);
        send_item(swpl_pkg::CMD_INSERT, 9'h003, {WGT_W{1'b1}} - 1'b1);
    endtask

    task automatic test_saturation();
        send_item(swpl_pkg::CMD_COUNT, 9'h003, '0);
        send_item(swpl_pkg::CMD_COUNT, 9'h003, '0);
        send_item(swpl_pkg::CMD_COUNT, 9'h0AA, '0);
    endtask

    task automatic test_duplicate_tags();
        send_item(swpl_pkg::CMD_INSERT, 9'd0, 20'd1);
        send_item(swpl_pkg::CMD_COUNT, 9'd0, '0);
    endtask

    task automatic test_remove_order();
        repeat (8) send_item(swpl_pkg::CMD_REMOVE, rand_tag(), rand_weight());
    endtask

    task automatic test_random_mix(input int n_items);
        int sel;
        int remove_pct;
        repeat (n_items) begin
            remove_pct = (list_fill > 24) ? 45 : 15;
            sel        = $urandom_range(0, 99);
            if (sel < remove_pct) send_item(swpl_pkg::CMD_REMOVE, rand_tag(), rand_weight());
            else if (sel < remove_pct + 25)
                send_item(swpl_pkg::CMD_INSERT, rand_tag(), pick_weight());
            else if (sel < remove_pct + 28) send_item(CMD_UNUSED, rand_tag(), rand_weight());
            else send_item(swpl_pkg::CMD_COUNT, pick_count_tag(), rand_weight());
        end
    endtask

    task automatic test_fill_to_full();
        int sel;
        while (list_fill < LIST_DEPTH) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) send_item(swpl_pkg::CMD_INSERT, rand_tag(), pick_weight());
            else if (sel < 94) send_item(swpl_pkg::CMD_COUNT, rand_tag(), rand_weight());
            else if (sel < 98) send_item(swpl_pkg::CMD_REMOVE, rand_tag(), rand_weight());
            else send_item(CMD_UNUSED, rand_tag(), rand_weight());
        end
    endtask

    task automatic test_full_list();
        int absent;
        send_item(swpl_pkg::CMD_INSERT, rand_tag(), pick_weight());
        absent = find_absent_tag();
        if (absent >= 0) send_item(swpl_pkg::CMD_COUNT, TAG_W'(absent), rand_weight());
        send_item(swpl_pkg::CMD_COUNT, pick_present_tag(), rand_weight());
        send_item(CMD_UNUSED, rand_tag(), rand_weight());
        send_item(swpl_pkg::CMD_REMOVE, rand_tag(), rand_weight());
        absent = find_absent_tag();
        if (absent >= 0) send_item(swpl_pkg::CMD_COUNT, TAG_W'(absent), rand_weight());
        else send_item(swpl_pkg::CMD_INSERT, rand_tag(), pick_weight());
        send_item(swpl_pkg::CMD_INSERT, rand_tag(), '1);
    endtask

    task automatic test_drain_to_empty();
        int sel;
        while (list_fill > 0) begin
            sel = $urandom_range(0, 99);
            if (sel < 94) send_item(swpl_pkg::CMD_REMOVE, rand_tag(), rand_weight());
            else if (sel < 98)
                send_item(swpl_pkg::CMD_COUNT, pick_present_tag(), rand_weight());
            else send_item(CMD_UNUSED, rand_tag(), rand_weight());
        end
        repeat (2) send_item(swpl_pkg::CMD_REMOVE, rand_tag(), rand_weight());
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d tag %0d weight %0d held %0d",
                         $time, o_status, o_out_tag, o_out_weight, o_entries_held);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("out_tag", 32'(want.tag), 32'(o_out_tag));
                check_field("out_weight", 32'(want.weight), 32'(o_out_weight));
                check_field("entries_held", 32'(want.held), 32'(o_entries_held));
                status_seen[o_status]++;
                results_checked++;
            end
        end
    end

    // Every transaction finishes within a bounded walk of the list, so a long quiet
    // stretch means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("sorted_weight_priority_list_test: errors");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_unused();
        test_count_ordering();
        test_insert_ordering();
        test_saturation();
        test_duplicate_tags();
        test_remove_order();
        wait_drained();
        test_random_mix(MIX_ITEMS);
        wait_drained();
        test_fill_to_full();
        test_full_list();
        wait_drained();
        test_drain_to_empty();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d transactions, %0d results checked; list peaked at %0d of %0d entries.",
                 items_sent, results_checked, peak_fill, LIST_DEPTH);
        $display("Status ok/full/empty/saturated: %0d/%0d/%0d/%0d; %0d counts moved past lighter.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 moves_past_lighter);
        if (errors == 0) begin
            $display("sorted_weight_priority_list_test: clean");
        end else begin
            $display("sorted_weight_priority_list_test: errors");
        end
        $finish;
    end

endmodule

// File: sorted_weight_priority_list.f
hw/rtl/swpl_pkg.sv
hw/rtl/swpl_ctrl.sv
hw/rtl/swpl_dpath.sv
hw/rtl/sorted_weight_priority_list.sv
tb/sorted_weight_priority_list_test.sv
